### rtl/lztd_pkg.sv
`timescale 1ns / 1ps

package lztd_pkg;

	// Default geometry of the decoder.
	localparam int DEF_WINDOW_SIZE = 4096;
	localparam int DEF_DIST_BITS   = 12;
	localparam int DEF_LEN_BITS    = 4;

	// Absolute stream positions are 32 bits and wrap.
	localparam int POS_W  = 32;
	localparam int BYTE_W = 8;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;   // load a new token
		logic issue;    // start one output byte this cycle
		logic lit;      // the byte being issued is the literal
	} lztd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic issue_ok;   // the byte stage can take a new byte
		logic last_copy;  // the copy byte being issued is the final one
		logic zero_len;   // the token on the input has no copy part
	} lztd_sts_t;

endpackage

### rtl/lztd_ctrl.sv
`timescale 1ns / 1ps

module lztd_ctrl
	import lztd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  lztd_sts_t sts,
	output lztd_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_COPY = 2'd1;
	localparam logic [1:0] ST_LIT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.accept = in_valid && in_ready;
	assign cmd.issue  = ((state_q == ST_COPY) || (state_q == ST_LIT)) && sts.issue_ok;
	assign cmd.lit    = (state_q == ST_LIT);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept) begin
					state_d = sts.zero_len ? ST_LIT : ST_COPY;
				end
			end
			ST_COPY: begin
				if (sts.issue_ok && sts.last_copy) begin
					state_d = ST_LIT;
				end
			end
			ST_LIT: begin
				if (sts.issue_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A token is never taken twice.
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !in_ready)
		else $error("controller stayed idle after taking a token");

	// The final copy byte hands over to the literal.
	a_copy_to_lit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) && cmd.issue && sts.last_copy |=> (state_q == ST_LIT))
		else $error("literal did not follow the last copy byte");

	// Issuing the literal finishes the token.
	a_lit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue && cmd.lit |=> in_ready)
		else $error("controller did not return to idle after the literal");

endmodule

### rtl/lztd_datapath.sv
`timescale 1ns / 1ps

module lztd_datapath
	import lztd_pkg::*;
#(
	parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
	parameter int DIST_BITS   = DEF_DIST_BITS,
	parameter int LEN_BITS    = DEF_LEN_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [DIST_BITS-1:0] distance,
	input  logic [LEN_BITS-1:0]  copy_length,
	input  logic [BYTE_W-1:0]    next_byte,
	input  lztd_cmd_t            cmd,
	output lztd_sts_t            sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    data_byte,
	output logic                 last,
	output logic                 bad_reference
);

	localparam int ADDR_W = $clog2(WINDOW_SIZE);

	// Token and position state.
	logic [POS_W-1:0]     wp_q;
	logic [POS_W-1:0]     base_q;
	logic [DIST_BITS-1:0] dist_q;
	logic [LEN_BITS-1:0]  len_q;
	logic [LEN_BITS-1:0]  cnt_q;
	logic [BYTE_W-1:0]    lit_q;

	// Byte stage: one byte whose history read is in flight.
	logic                 s1_valid_q;
	logic                 lit_s1;
	logic                 bad_s1;
	logic                 fwd_s1;
	logic [ADDR_W-1:0]    pos_s1;
	logic [BYTE_W-1:0]    litb_s1;
	logic [BYTE_W-1:0]    rd_q;
	logic [BYTE_W-1:0]    last_byte_q;

	// Output register.
	logic                 out_valid_q;
	logic [BYTE_W-1:0]    data_q;
	logic                 last_q;
	logic                 bad_q;

	logic [BYTE_W-1:0]    hist_mem [WINDOW_SIZE];

	logic [POS_W-1:0]     src;
	logic                 src_bad;
	logic                 s1_move;
	logic                 issue_copy;
	logic [POS_W-1:0]     wp_next;
	logic [BYTE_W-1:0]    s1_byte;

	assign src        = base_q + POS_W'(dist_q) + POS_W'(cnt_q);
	assign src_bad    = !(src < wp_q);
	assign s1_move    = s1_valid_q && (!out_valid_q || out_ready);
	assign issue_copy = cmd.issue && !cmd.lit;
	assign wp_next    = wp_q + POS_W'(1);

	// A copy byte that reads the byte written in the same cycle takes it from last_byte_q.
	always_comb begin
		if (lit_s1) begin
			s1_byte = litb_s1;
		end else if (bad_s1) begin
			s1_byte = '0;
		end else if (fwd_s1) begin
			s1_byte = last_byte_q;
		end else begin
			s1_byte = rd_q;
		end
	end

	assign sts.issue_ok  = !s1_valid_q || s1_move;
	assign sts.last_copy = (cnt_q == (len_q - LEN_BITS'(1)));
	assign sts.zero_len  = (copy_length == '0);

	assign out_valid     = out_valid_q;
	assign data_byte     = data_q;
	assign last          = last_q;
	assign bad_reference = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			base_q      <= '0;
			cnt_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				cnt_q <= '0;
			end else if (issue_copy) begin
				cnt_q <= cnt_q + LEN_BITS'(1);
			end
			if (cmd.issue) begin
				wp_q <= wp_next;
				if (cmd.lit && (wp_next > POS_W'(WINDOW_SIZE))) begin
					base_q <= wp_next - POS_W'(WINDOW_SIZE);
				end
			end
			if (cmd.issue) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dist_q <= distance;
			len_q  <= copy_length;
			lit_q  <= next_byte;
		end
		if (cmd.issue) begin
			lit_s1  <= cmd.lit;
			bad_s1  <= !cmd.lit && src_bad;
			fwd_s1  <= !cmd.lit && s1_move && (src[ADDR_W-1:0] == pos_s1);
			pos_s1  <= wp_q[ADDR_W-1:0];
			litb_s1 <= lit_q;
		end
		if (s1_move) begin
			last_byte_q <= s1_byte;
			data_q      <= s1_byte;
			last_q      <= lit_s1;
			bad_q       <= bad_s1;
		end
	end

	// History store: read for the copy byte being issued, write for the byte leaving the stage.
	always_ff @(posedge clk) begin
		if (issue_copy) begin
			rd_q <= hist_mem[src[ADDR_W-1:0]];
		end
		if (s1_move) begin
			hist_mem[pos_s1] <= s1_byte;
		end
	end

	a_issue_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> sts.issue_ok)
		else $error("byte issued while the byte stage was full");

	a_literal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> !bad_q)
		else $error("literal marked as a bad reference");

	a_stage_flags: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && lit_s1 |-> !bad_s1 && !fwd_s1)
		else $error("literal in the byte stage carries copy flags");

endmodule

### rtl/lz77_triple_decoder_top.sv
`timescale 1ns / 1ps

// LZ77 triple decoder. Each input transaction is one token (distance, copy_length,
// next_byte). The block copies copy_length bytes, one per cycle unless the output
// stalls, from the absolute output position window_base + distance + i, then emits
// the literal next_byte with tlast set; a token with copy_length zero emits only the
// literal. Copies may overlap the bytes of the same token. A source that is not below
// the current write position yields a zero byte with tuser (bad_reference) set, and
// that zero enters the history like any other byte. Decoded bytes are kept in a
// WINDOW_SIZE-entry history memory indexed by position modulo WINDOW_SIZE;
// WINDOW_SIZE must be a power of two. Its contents are undefined until written, so
// there is no clearing pass after reset. The token is taken first, then each output
// byte is issued in turn through the single read port of the history memory.
// A new token is taken only after the previous one has issued its literal; the last
// output byte may still be in the byte stage or the output register at that time.
module lz77_triple_decoder_top
	import lztd_pkg::*;
#(
	parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
	parameter int DIST_BITS   = DEF_DIST_BITS,
	parameter int LEN_BITS    = DEF_LEN_BITS,
	localparam int IN_W       = ((DIST_BITS + LEN_BITS + BYTE_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // distance, copy_length, next_byte, zero fill
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,   // data_byte
	output logic              m_tlast,   // last
	output logic              m_tuser    // bad_reference
);

	lztd_cmd_t cmd;
	lztd_sts_t sts;

	logic [DIST_BITS-1:0] distance;
	logic [LEN_BITS-1:0]  copy_length;
	logic [BYTE_W-1:0]    next_byte;

	// Unpack the token; any fill bits above next_byte are ignored.
	assign distance    = s_tdata[DIST_BITS-1:0];
	assign copy_length = s_tdata[DIST_BITS +: LEN_BITS];
	assign next_byte   = s_tdata[DIST_BITS+LEN_BITS +: BYTE_W];

	// Sequencer: takes a token, then walks the copy bytes and the literal.
	lztd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Positions, history memory, byte stage and output register.
	lztd_datapath #(
		.WINDOW_SIZE (WINDOW_SIZE),
		.DIST_BITS   (DIST_BITS),
		.LEN_BITS    (LEN_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.distance      (distance),
		.copy_length   (copy_length),
		.next_byte     (next_byte),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.data_byte     (m_tdata),
		.last          (m_tlast),
		.bad_reference (m_tuser)
	);

endmodule

### bench/lztd_decode_checker.sv
`timescale 1ns / 1ps

module lztd_decode_checker
	import lztd_pkg::*;
#(
	parameter int IN_W = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [BYTE_W-1:0] m_tdata,
	input  logic              m_tlast,
	input  logic              m_tuser,
	output int                mismatch_count,
	output int                bytes_pending
);

	localparam int HIST_AW = $clog2(DEF_WINDOW_SIZE);
	localparam int LEN_LO  = DEF_DIST_BITS;
	localparam int LIT_LO  = DEF_DIST_BITS + DEF_LEN_BITS;
	localparam logic [POS_W-1:0] WINDOW_LEN = DEF_WINDOW_SIZE;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              bad;
	} decoded_byte_t;

	logic [BYTE_W-1:0] history [DEF_WINDOW_SIZE];
	logic [POS_W-1:0]  write_pos;
	logic [POS_W-1:0]  window_start;
	decoded_byte_t     expected_bytes [$];
	int                byte_index;

	initial begin
		mismatch_count = 0;
		bytes_pending  = 0;
	end

	// Queues one predicted byte and records it in the history like the decoder does.
	task automatic put_byte(input logic [BYTE_W-1:0] b, input logic last, input logic bad);
		decoded_byte_t e;
		e.data = b;
		e.last = last;
		e.bad  = bad;
		expected_bytes.push_back(e);
		history[write_pos[HIST_AW-1:0]] = b;
		write_pos = write_pos + 1'b1;
	endtask

	task automatic decode_token(input logic [DEF_DIST_BITS-1:0] src_dist,
			input logic [DEF_LEN_BITS-1:0] len, input logic [BYTE_W-1:0] lit);
		logic [POS_W-1:0] src;
		for (int i = 0; i < len; i++) begin
			src = window_start + POS_W'(src_dist) + POS_W'(i);
			// A source at or past the write position has not been produced yet.
			if (src < write_pos)
				put_byte(history[src[HIST_AW-1:0]], 1'b0, 1'b0);
			else
				put_byte('0, 1'b0, 1'b1);
		end
		put_byte(lit, 1'b1, 1'b0);
		if (write_pos > WINDOW_LEN)
			window_start = write_pos - WINDOW_LEN;
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_byte_t e;
		if (!arst_n) begin
			write_pos    = '0;
			window_start = '0;
			byte_index   = 0;
			expected_bytes.delete();
		end else begin
			if (s_tvalid && s_tready)
				decode_token(s_tdata[DEF_DIST_BITS-1:0], s_tdata[LIT_LO-1:LEN_LO],
					s_tdata[LIT_LO+BYTE_W-1:LIT_LO]);
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					if (mismatch_count < 10)
						$display("byte %0d: unexpected output, data %02h last %b bad %b",
							byte_index, m_tdata, m_tlast, m_tuser);
					mismatch_count++;
				end else begin
					e = expected_bytes.pop_front();
					if (m_tdata !== e.data || m_tlast !== e.last || m_tuser !== e.bad) begin
						if (mismatch_count < 10)
							$display("byte %0d: expected %02h/%b/%b, got %02h/%b/%b",
								byte_index, e.data, e.last, e.bad,
								m_tdata, m_tlast, m_tuser);
						mismatch_count++;
					end
				end
				byte_index++;
			end
		end
		bytes_pending <= expected_bytes.size();
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the LZ77 triple decoder. The checker beside the
// decoder predicts every output byte and counts mismatches; this module only
// drives tokens, toggles the output ready and decides the outcome.
module tb_top
	import lztd_pkg::*;
();

	localparam int IN_W         = ((DEF_DIST_BITS + DEF_LEN_BITS + BYTE_W + 7) / 8) * 8;
	localparam int WINDOW_BYTES = DEF_WINDOW_SIZE;
	localparam int DIST_MAX     = (1 << DEF_DIST_BITS) - 1;
	localparam int LEN_MAX      = (1 << DEF_LEN_BITS) - 1;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic [IN_W-1:0]   s_tdata  = '0;
	logic              m_tready = 1'b0;
	wire               s_tready;
	wire               m_tvalid;
	wire  [BYTE_W-1:0] m_tdata;
	wire               m_tlast;
	wire               m_tuser;

	int mismatch_count;
	int bytes_pending;

	// Idle percentages of the token sender and the byte receiver.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// Number of bytes the accepted tokens produce; it tells the random part how much
	// history exists, so most back-references can point at written bytes.
	logic [POS_W-1:0] bytes_sent = '0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	lz77_triple_decoder_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	lztd_decode_checker #(.IN_W(IN_W)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.m_tuser        (m_tuser),
		.mismatch_count (mismatch_count),
		.bytes_pending  (bytes_pending)
	);

	// The receiver stalls at random, once per clock, at the current idle rate.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Offers one token and returns at the edge where the transaction completes. The
	// valid stays high on return, so a following token without a gap needs only one
	// assignment in that time step.
	task automatic send_token(input logic [DEF_DIST_BITS-1:0] token_dist,
			input logic [DEF_LEN_BITS-1:0] len, input logic [BYTE_W-1:0] lit);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {lit, len, token_dist};
		do @(posedge clk); while (!s_tready);
		bytes_sent = bytes_sent + POS_W'(len) + POS_W'(1);
	endtask

	// Holds the sender off until every predicted byte has been seen on the output.
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (bytes_pending != 0);
	endtask

	// Mostly well-formed tokens: long copies from bytes already written, some short
	// overlapping repeats of the latest four bytes, the rest with any distance, which
	// gives unwritten sources while the history is still filling.
	task automatic send_random_tokens(input int count);
		logic [DEF_DIST_BITS-1:0] token_dist;
		logic [DEF_LEN_BITS-1:0]  len;
		int                       pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				if (bytes_sent >= WINDOW_BYTES)
					token_dist = DEF_DIST_BITS'(WINDOW_BYTES - $urandom_range(4, 1));
				else if (bytes_sent > 4)
					token_dist = DEF_DIST_BITS'(bytes_sent - $urandom_range(4, 1));
				else
					token_dist = '0;
			end else if (pick < 70) begin
				if (bytes_sent >= WINDOW_BYTES)
					token_dist = DEF_DIST_BITS'($urandom_range(DIST_MAX, 0));
				else
					token_dist = DEF_DIST_BITS'($urandom_range(bytes_sent - 1, 0));
			end else begin
				token_dist = DEF_DIST_BITS'($urandom_range(DIST_MAX, 0));
			end
			pick = $urandom_range(99);
			if (pick < 75)
				len = DEF_LEN_BITS'($urandom_range(LEN_MAX, LEN_MAX - 3));
			else if (pick < 95)
				len = DEF_LEN_BITS'($urandom_range(LEN_MAX, 0));
			else
				len = '0;
			send_token(token_dist, len, BYTE_W'($urandom_range(255, 0)));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: the sender rarely idles, the receiver stalls often.
		send_idle_pct = 7;
		recv_idle_pct = 55;

		// Directed tokens. The first two are bare literals right after reset, then a
		// copy that overlaps its own output from position zero, and a copy whose
		// sources are all beyond the written bytes.
		send_token('0, '0, 8'h00);
		send_token('0, '0, 8'hFF);
		send_token('0, DEF_LEN_BITS'(LEN_MAX), 8'hA5);
		send_token(DEF_DIST_BITS'(DIST_MAX), DEF_LEN_BITS'(LEN_MAX), 8'h5A);
		send_token('0, DEF_LEN_BITS'(1), 8'h01);
		// A nonzero distance with no copy still emits only the literal.
		send_token(DEF_DIST_BITS'(17), '0, 8'h80);
		send_token(DEF_DIST_BITS'(10), DEF_LEN_BITS'(8), 8'h7F);
		// Run-length style repeat of the newest byte.
		send_token(DEF_DIST_BITS'(bytes_sent - 1), DEF_LEN_BITS'(LEN_MAX), 8'h3C);
		// A source exactly at the write position is not written yet.
		send_token(DEF_DIST_BITS'(bytes_sent), DEF_LEN_BITS'(4), 8'hC3);
		send_token(DEF_DIST_BITS'(bytes_sent - 1), DEF_LEN_BITS'(1), 8'h96);
		send_token(12'hAAA, DEF_LEN_BITS'(10), 8'h55);
		send_token(12'h555, DEF_LEN_BITS'(5), 8'hAA);
		send_token(DEF_DIST_BITS'(DIST_MAX), '0, 8'hFF);
		send_token('0, DEF_LEN_BITS'(LEN_MAX), 8'h00);
		send_token(DEF_DIST_BITS'(2048), DEF_LEN_BITS'(LEN_MAX), 8'h69);

		// Let everything come out before the random part starts.
		wait_for_drain();
		send_random_tokens(95);
		wait_for_drain();

		// Phase two: the roles swap.
		send_idle_pct = 55;
		recv_idle_pct = 7;
		send_random_tokens(95);
		wait_for_drain();

		// Phase three: no idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random_tokens(95);

		wait_for_drain();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && bytes_pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
rtl/lztd_pkg.sv
rtl/lztd_ctrl.sv
rtl/lztd_datapath.sv
rtl/lz77_triple_decoder_top.sv
bench/lztd_decode_checker.sv
bench/tb_top.sv
